// ----- rtl/core/heightmap_bilinear_sampler_assert.svh -----
// Assertion macros for the heightmap bilinear sampler.
// Included by the RTL modules that carry concurrent checks; no other dependencies.
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_ASSERT_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_ASSERT_SVH

`ifndef SYNTHESIS

`define HBS_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("heightmap sampler: property violated");

`define HBS_ASSERT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("heightmap sampler: forbidden condition seen");

`else

`define HBS_ASSERT(lbl, clk, rstn, prop)

`define HBS_ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

// ----- rtl/core/hbs_pkg.sv -----
// Shared types, constants and address helper for the heightmap bilinear sampler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hbs_pkg;

	localparam int GRID_SIZE   = 256;
	localparam int DEPTH       = GRID_SIZE * GRID_SIZE;
	localparam int IDX_W       = $clog2(GRID_SIZE);
	localparam int ADDR_W      = $clog2(DEPTH);

	localparam int H_W         = 16;
	localparam int W_W         = 17;
	localparam int FRAC_W      = 8;

	localparam int MAP_HALF    = 200;
	localparam int MAP_SPAN    = 2 * MAP_HALF;
	localparam int WORLD_LIMIT = MAP_HALF * 256;
	localparam int U_MAX       = 2 * WORLD_LIMIT;
	localparam int U_W         = $clog2(U_MAX + 1);

	// grid position = floor(u * GRID_SIZE / MAP_SPAN) through a reciprocal
	localparam int P_W         = $clog2(U_MAX * GRID_SIZE + 1);
	localparam int SH          = P_W + 9;
	localparam int RECIP_W     = SH - 8;
	localparam int M_W         = P_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << SH) / 64'(MAP_SPAN));
	localparam int G_MAX       = GRID_SIZE * 256;
	localparam int G_W         = $clog2(G_MAX + 1);
	localparam int I_W         = G_W - FRAC_W;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic {
		CMD_WRITE  = 1'b0,
		CMD_SAMPLE = 1'b1
	} cmd_t;

	typedef struct packed {
		idx_t              idx0;
		idx_t              idx1;
		logic [FRAC_W-1:0] frac;
	} axis_pos_t;

	typedef struct packed {
		logic ld_a;
		logic ld_l1;
		logic ld_c;
		logic ld_l2;
		logic ld_s;
	} blend_ctl_t;

	function automatic addr_t grid_addr(input idx_t x, input idx_t z);
		return ADDR_W'(x) * ADDR_W'(GRID_SIZE) + ADDR_W'(z);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/hbs_if.sv -----
// Handshake channels of the heightmap bilinear sampler: command in, height out.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface hbs_cmd_if;
	logic               valid;
	logic               ready;
	logic               command;
	logic [7:0]         grid_x;
	logic [7:0]         grid_z;
	logic signed [15:0] height_value;
	logic signed [16:0] world_x;
	logic signed [16:0] world_z;

	modport source (output valid, command, grid_x, grid_z, height_value, world_x, world_z,
		input ready);
	modport sink (input valid, command, grid_x, grid_z, height_value, world_x, world_z,
		output ready);
endinterface

interface hbs_res_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sampled_height;

	modport source (output valid, sampled_height, input ready);
	modport sink (input valid, sampled_height, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/hbs_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hbs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/hbs_map.sv -----
// World to grid mapping for one axis: saturate, scale by GRID_SIZE / 400, split, clamp.
// Depends on hbs_pkg and heightmap_bilinear_sampler_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "heightmap_bilinear_sampler_assert.svh"

module hbs_map (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    load,
	input  wire logic signed [16:0]      world,
	output logic                         pos_valid,
	output hbs_pkg::axis_pos_t           pos
);

	logic                         v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [hbs_pkg::U_W-1:0]      u_s1;
	logic [hbs_pkg::P_W-1:0]      p_s2, p_s3;
	logic [hbs_pkg::M_W-1:0]      m_s3;
	logic [hbs_pkg::G_W-1:0]      g_s4;
	hbs_pkg::axis_pos_t           pos_s5;

	logic signed [17:0]           offs;
	logic [hbs_pkg::U_W-1:0]      u_sat;
	logic [hbs_pkg::G_W-1:0]      q0;
	logic [hbs_pkg::P_W-1:0]      rem;
	logic [hbs_pkg::G_W-1:0]      g_fix;
	logic [hbs_pkg::I_W-1:0]      ix;
	logic [hbs_pkg::I_W-1:0]      ix_nxt;
	hbs_pkg::axis_pos_t           pos_nxt;

	// saturate to the map
	always_comb begin
		offs = 18'(world) + 18'(hbs_pkg::WORLD_LIMIT);
		if (offs < 18'sd0) begin
			u_sat = '0;
		end else if (offs > $signed(18'(hbs_pkg::U_MAX))) begin
			u_sat = hbs_pkg::U_W'(hbs_pkg::U_MAX);
		end else begin
			u_sat = offs[hbs_pkg::U_W-1:0];
		end
	end

	// reciprocal quotient, corrected once
	always_comb begin
		q0    = m_s3[hbs_pkg::SH +: hbs_pkg::G_W];
		rem   = p_s3 - hbs_pkg::P_W'(q0) * hbs_pkg::P_W'(hbs_pkg::MAP_SPAN);
		g_fix = (rem >= hbs_pkg::P_W'(hbs_pkg::MAP_SPAN)) ? q0 + hbs_pkg::G_W'(1) : q0;
	end

	// clamp-to-edge neighbour indices
	always_comb begin
		ix           = g_s4[hbs_pkg::G_W-1:hbs_pkg::FRAC_W];
		ix_nxt       = ix + hbs_pkg::I_W'(1);
		pos_nxt.frac = g_s4[hbs_pkg::FRAC_W-1:0];
		if (ix >= hbs_pkg::I_W'(hbs_pkg::GRID_SIZE - 1)) begin
			pos_nxt.idx0 = hbs_pkg::IDX_W'(hbs_pkg::GRID_SIZE - 1);
			pos_nxt.idx1 = hbs_pkg::IDX_W'(hbs_pkg::GRID_SIZE - 1);
		end else begin
			pos_nxt.idx0 = ix[hbs_pkg::IDX_W-1:0];
			pos_nxt.idx1 = ix_nxt[hbs_pkg::IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= load;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		u_s1   <= u_sat;
		p_s2   <= hbs_pkg::P_W'(u_s1) * hbs_pkg::P_W'(hbs_pkg::GRID_SIZE);
		p_s3   <= p_s2;
		m_s3   <= hbs_pkg::M_W'(p_s2) * hbs_pkg::M_W'(hbs_pkg::RECIP);
		g_s4   <= g_fix;
		pos_s5 <= pos_nxt;
	end

	assign pos_valid = v_s5;
	assign pos       = pos_s5;

	`HBS_ASSERT(a_rem_once, clk, arst_n, v_s3 |-> rem < hbs_pkg::P_W'(2 * hbs_pkg::MAP_SPAN))
	`HBS_ASSERT(a_g_range, clk, arst_n, v_s4 |-> g_s4 <= hbs_pkg::G_W'(hbs_pkg::G_MAX))
	`HBS_ASSERT(a_idx_pair, clk, arst_n,
		v_s5 |-> (pos_s5.idx1 == pos_s5.idx0 || pos_s5.idx1 == pos_s5.idx0 + hbs_pkg::IDX_W'(1)))

endmodule

`default_nettype wire

// ----- rtl/core/hbs_blend.sv -----
// Bilinear blend of four neighbour heights: along z, then along x, then round to Q8.8.
// Depends on hbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hbs_blend (
	input  wire logic                    clk,
	input  wire hbs_pkg::blend_ctl_t     ctl,
	input  wire logic [15:0]             rdata,
	input  wire logic [7:0]              fx,
	input  wire logic [7:0]              fz,
	output logic signed [15:0]           height
);

	logic signed [15:0] a_q, c_q;
	logic signed [23:0] l1_q, l2_q;
	logic signed [31:0] s_q;
	logic signed [32:0] rnd;

	function automatic logic signed [23:0] lerp_z(input logic signed [15:0] lo,
		input logic signed [15:0] hi, input logic [7:0] f);
		logic signed [16:0] diff;
		logic signed [25:0] prod;
		logic signed [25:0] acc;
		diff = 17'(hi) - 17'(lo);
		prod = 26'(diff) * 26'($signed({1'b0, f}));
		acc  = (26'(lo) <<< 8) + prod;
		return acc[23:0];
	endfunction

	function automatic logic signed [31:0] lerp_x(input logic signed [23:0] lo,
		input logic signed [23:0] hi, input logic [7:0] f);
		logic signed [24:0] diff;
		logic signed [33:0] prod;
		logic signed [33:0] acc;
		diff = 25'(hi) - 25'(lo);
		prod = 34'(diff) * 34'($signed({1'b0, f}));
		acc  = (34'(lo) <<< 8) + prod;
		return acc[31:0];
	endfunction

	always_ff @(posedge clk) begin
		if (ctl.ld_a) begin
			a_q <= $signed(rdata);
		end
		if (ctl.ld_l1) begin
			l1_q <= lerp_z(a_q, $signed(rdata), fz);
		end
		if (ctl.ld_c) begin
			c_q <= $signed(rdata);
		end
		if (ctl.ld_l2) begin
			l2_q <= lerp_z(c_q, $signed(rdata), fz);
		end
		if (ctl.ld_s) begin
			s_q <= lerp_x(l1_q, l2_q, fx);
		end
	end

	// round half up
	assign rnd    = 33'(s_q) + 33'sd32768;
	assign height = rnd[31:16];

endmodule

`default_nettype wire

// ----- rtl/core/heightmap_bilinear_sampler.sv -----
// Top level of the heightmap bilinear sampler: sequencer, height grid RAM, output register.
// Depends on hbs_pkg, hbs_if, hbs_ram, hbs_map, hbs_blend and the assertion header.
//
//   channel  dir  payload                                                  transaction
//   cmd      in   command, grid_x, grid_z, height_value, world_x, world_z  valid & ready
//   res      out  sampled_height                                           valid & ready
//
// A write leaves the state in S_IDLE; the next command is taken in the following cycle.
// Until the next acceptance a sample passes the axis mapping pipeline (S_MAP), four RAM
// reads of the neighbours (S_RD_A to S_RD_D), then the x blend (S_MIX) and the result load.
// A finished height waits in the output register; new commands are taken while it waits.
// A sample stalls only when its height is ready and the previous one is still untaken.
// Grid contents are not cleared by reset.
`timescale 1ns / 1ps
`default_nettype none
`include "heightmap_bilinear_sampler_assert.svh"

module heightmap_bilinear_sampler (
	input  wire logic clk,
	input  wire logic arst_n,
	hbs_cmd_if.sink   cmd,
	hbs_res_if.source res
);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_MAP  = 9'b000000010,
		S_RD_A = 9'b000000100,
		S_RD_B = 9'b000001000,
		S_RD_C = 9'b000010000,
		S_RD_D = 9'b000100000,
		S_LAST = 9'b001000000,
		S_MIX  = 9'b010000000,
		S_DONE = 9'b100000000
	} state_t;

	state_t                 state_q, state_nxt;
	hbs_pkg::axis_pos_t     pos_x_q, pos_z_q;
	logic                   out_valid_q;
	logic signed [15:0]     out_data_q;

	logic                   cmd_acc;
	logic                   is_sample;
	logic                   wr_ok;
	logic                   ram_we;
	hbs_pkg::addr_t         ram_waddr;
	logic                   ram_re;
	hbs_pkg::addr_t         ram_raddr;
	logic [15:0]            ram_rdata;
	logic                   map_load;
	logic                   map_vld_x, map_vld_z;
	hbs_pkg::axis_pos_t     map_pos_x, map_pos_z;
	hbs_pkg::blend_ctl_t    bctl;
	logic signed [15:0]     blend_h;
	logic                   load_out;

	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign is_sample = (cmd.command == hbs_pkg::CMD_SAMPLE);
	assign wr_ok     = (32'(cmd.grid_x) < 32'(hbs_pkg::GRID_SIZE))
		&& (32'(cmd.grid_z) < 32'(hbs_pkg::GRID_SIZE));
	assign ram_we    = cmd_acc && !is_sample && wr_ok;
	assign ram_waddr = hbs_pkg::grid_addr(hbs_pkg::IDX_W'(cmd.grid_x),
		hbs_pkg::IDX_W'(cmd.grid_z));
	assign map_load  = cmd_acc && is_sample;

	hbs_map u_map_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (map_load),
		.world     (cmd.world_x),
		.pos_valid (map_vld_x),
		.pos       (map_pos_x)
	);

	hbs_map u_map_z (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (map_load),
		.world     (cmd.world_z),
		.pos_valid (map_vld_z),
		.pos       (map_pos_z)
	);

	// neighbour read order: a, b, c, d
	always_comb begin
		ram_re = state_q inside {S_RD_A, S_RD_B, S_RD_C, S_RD_D};
		case (state_q)
			S_RD_A:  ram_raddr = hbs_pkg::grid_addr(pos_x_q.idx0, pos_z_q.idx0);
			S_RD_B:  ram_raddr = hbs_pkg::grid_addr(pos_x_q.idx0, pos_z_q.idx1);
			S_RD_C:  ram_raddr = hbs_pkg::grid_addr(pos_x_q.idx1, pos_z_q.idx0);
			S_RD_D:  ram_raddr = hbs_pkg::grid_addr(pos_x_q.idx1, pos_z_q.idx1);
			default: ram_raddr = hbs_pkg::grid_addr(pos_x_q.idx0, pos_z_q.idx0);
		endcase
	end

	hbs_ram #(
		.WIDTH (hbs_pkg::H_W),
		.DEPTH (hbs_pkg::DEPTH),
		.AW    (hbs_pkg::ADDR_W)
	) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (cmd.height_value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		bctl.ld_a  = (state_q == S_RD_B);
		bctl.ld_l1 = (state_q == S_RD_C);
		bctl.ld_c  = (state_q == S_RD_D);
		bctl.ld_l2 = (state_q == S_LAST);
		bctl.ld_s  = (state_q == S_MIX);
	end

	hbs_blend u_blend (
		.clk    (clk),
		.ctl    (bctl),
		.rdata  (ram_rdata),
		.fx     (pos_x_q.frac),
		.fz     (pos_z_q.frac),
		.height (blend_h)
	);

	assign load_out = (state_q == S_DONE) && (!out_valid_q || res.ready);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (map_load) begin
					state_nxt = S_MAP;
				end
			end
			S_MAP: begin
				if (map_vld_x) begin
					state_nxt = S_RD_A;
				end
			end
			S_RD_A:  state_nxt = S_RD_B;
			S_RD_B:  state_nxt = S_RD_C;
			S_RD_C:  state_nxt = S_RD_D;
			S_RD_D:  state_nxt = S_LAST;
			S_LAST:  state_nxt = S_MIX;
			S_MIX:   state_nxt = S_DONE;
			S_DONE: begin
				if (load_out) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_MAP && map_vld_x) begin
			pos_x_q <= map_pos_x;
			pos_z_q <= map_pos_z;
		end
		if (load_out) begin
			out_data_q <= blend_h;
		end
	end

	assign res.valid          = out_valid_q;
	assign res.sampled_height = out_data_q;

	`HBS_ASSERT(a_map_latency, clk, arst_n, map_load |-> ##5 (map_vld_x && map_vld_z))
	`HBS_ASSERT(a_map_in_wait, clk, arst_n, map_vld_x |-> state_q == S_MAP)
	`HBS_ASSERT_NEVER(a_we_busy, clk, arst_n, ram_we && (ram_re || state_q != S_IDLE))

endmodule

`default_nettype wire

// ----- dv/heightmap_bilinear_sampler_checker.sv -----
// Scoreboard for the heightmap bilinear sampler: mirrors the height grid from accepted
// writes, predicts each sampled height and compares it with the result channel.
// Depends on hbs_pkg and the hbs_cmd_if / hbs_res_if channels.
`timescale 1ns / 1ps

module heightmap_bilinear_sampler_checker
	import hbs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	hbs_cmd_if          cmd,
	hbs_res_if          res,
	output int unsigned failures,
	output int unsigned outstanding,
	output int unsigned compared
);

	typedef struct {
		int lo;
		int hi;
		int frac;
	} axis_tap_t;

	logic signed [H_W-1:0] grid_mirror [GRID_SIZE*GRID_SIZE];
	logic signed [H_W-1:0] pending_heights [$];
	int unsigned           fail_cnt = 0;
	int unsigned           cmp_cnt  = 0;
	int unsigned           pend_cnt = 0;

	assign failures    = fail_cnt;
	assign compared    = cmp_cnt;
	assign outstanding = pend_cnt;

	function automatic axis_tap_t locate_axis(input logic signed [W_W-1:0] w);
		int        ws;
		int        g;
		int        i;
		axis_tap_t tap;
		ws = w;
		if (ws < -WORLD_LIMIT)
			ws = -WORLD_LIMIT;
		if (ws > WORLD_LIMIT)
			ws = WORLD_LIMIT;
		g = ((ws + WORLD_LIMIT) * GRID_SIZE) / MAP_SPAN;
		i = g >>> FRAC_W;
		tap.lo   = (i >= GRID_SIZE) ? GRID_SIZE - 1 : i;
		tap.hi   = (i + 1 >= GRID_SIZE) ? GRID_SIZE - 1 : i + 1;
		tap.frac = g & ((1 << FRAC_W) - 1);
		return tap;
	endfunction

	function automatic logic signed [H_W-1:0] blend_height(input logic signed [W_W-1:0] wx,
			input logic signed [W_W-1:0] wz);
		axis_tap_t px;
		axis_tap_t pz;
		longint    a, b, c, d;
		longint    l1, l2, s;
		px = locate_axis(wx);
		pz = locate_axis(wz);
		a  = grid_mirror[px.lo * GRID_SIZE + pz.lo];
		b  = grid_mirror[px.lo * GRID_SIZE + pz.hi];
		c  = grid_mirror[px.hi * GRID_SIZE + pz.lo];
		d  = grid_mirror[px.hi * GRID_SIZE + pz.hi];
		l1 = a * (256 - pz.frac) + b * pz.frac;
		l2 = c * (256 - pz.frac) + d * pz.frac;
		s  = l1 * (256 - px.frac) + l2 * px.frac;
		return H_W'((s + 64'sd32768) >>> 16);
	endfunction

	always @(posedge clk) begin
		logic signed [H_W-1:0] want;
		if (arst_n) begin
			// compare before predicting so a stray result is never matched to a new sample
			if (res.valid && res.ready) begin
				if (pending_heights.size() == 0) begin
					fail_cnt++;
					$display("%0t: sampled_height %0d arrived with no sample outstanding",
						$time, res.sampled_height);
				end else begin
					want = pending_heights.pop_front();
					cmp_cnt++;
					if (res.sampled_height !== want) begin
						fail_cnt++;
						$display("%0t: sampled_height mismatch, expected %0d, actual %0d",
							$time, want, res.sampled_height);
					end
				end
			end
			if (cmd.valid && cmd.ready) begin
				if (cmd.command == CMD_WRITE)
					grid_mirror[int'(cmd.grid_x) * GRID_SIZE + int'(cmd.grid_z)] = cmd.height_value;
				else
					pending_heights = {pending_heights, blend_height(cmd.world_x, cmd.world_z)};
			end
			pend_cnt = pending_heights.size();
		end
	end

endmodule

// ----- dv/heightmap_bilinear_sampler_tb.sv -----
// Testbench top for the heightmap bilinear sampler: clock, reset, command stimulus,
// result back-pressure and the verdict. Depends on hbs_pkg, hbs_if, the block and the
// checker module.
`timescale 1ns / 1ps

module heightmap_bilinear_sampler_tb;
	import hbs_pkg::*;

	localparam int ITEMS     = 1850;
	localparam int CELL_SPAN = MAP_SPAN * 256 / GRID_SIZE;
	localparam int LONG_HOLD = 500;
	localparam int DRAIN     = 60;

	logic        clk;
	logic        arst_n;
	int unsigned failures;
	int unsigned outstanding;
	int unsigned compared;

	bit          cell_written [GRID_SIZE*GRID_SIZE];
	bit          hold_request = 1'b0;
	int          burst_left   = 0;
	int          last_x       = 0;
	int          last_z       = 0;
	int unsigned items_sent   = 0;
	int unsigned writes_sent  = 0;
	int unsigned samples_sent = 0;

	hbs_cmd_if cmd_ch ();
	hbs_res_if res_ch ();

	heightmap_bilinear_sampler dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	heightmap_bilinear_sampler_checker scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_ch),
		.res         (res_ch),
		.failures    (failures),
		.outstanding (outstanding),
		.compared    (compared)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("timeout at %0t with %0d heights outstanding", $time, outstanding);
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int sender_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 6) begin
			burst_left = $urandom_range(10, 40);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [H_W-1:0] rand_height();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return 16'sh8000;
		if (r < 10)
			return 16'sh7fff;
		return H_W'($urandom);
	endfunction

	function automatic int world_cell(input logic signed [W_W-1:0] w);
		int ws;
		int i;
		ws = w;
		if (ws < -WORLD_LIMIT)
			ws = -WORLD_LIMIT;
		if (ws > WORLD_LIMIT)
			ws = WORLD_LIMIT;
		i = (((ws + WORLD_LIMIT) * GRID_SIZE) / MAP_SPAN) >>> FRAC_W;
		return (i >= GRID_SIZE) ? GRID_SIZE - 1 : i;
	endfunction

	function automatic logic signed [W_W-1:0] world_in_cell(input int i);
		return W_W'(i * CELL_SPAN + $urandom_range(0, CELL_SPAN - 1) - WORLD_LIMIT);
	endfunction

	function automatic logic signed [W_W-1:0] rim_world();
		case ($urandom_range(0, 3))
			0: return W_W'(-WORLD_LIMIT);
			1: return W_W'(WORLD_LIMIT);
			2: return 17'sh10000;
			default: return 17'sh0ffff;
		endcase
	endfunction

	function automatic int clamp_cell(input int i);
		if (i < 0)
			return 0;
		if (i >= GRID_SIZE)
			return GRID_SIZE - 1;
		return i;
	endfunction

	task automatic send_item(input cmd_t op, input logic [7:0] gx, input logic [7:0] gz,
			input logic signed [H_W-1:0] h, input logic signed [W_W-1:0] wx,
			input logic signed [W_W-1:0] wz);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid        <= 1'b1;
		cmd_ch.command      <= op;
		cmd_ch.grid_x       <= gx;
		cmd_ch.grid_z       <= gz;
		cmd_ch.height_value <= h;
		cmd_ch.world_x      <= wx;
		cmd_ch.world_z      <= wz;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		items_sent++;
		if (op == CMD_WRITE)
			writes_sent++;
		else
			samples_sent++;
	endtask

	task automatic write_height(input int x, input int z, input logic signed [H_W-1:0] h);
		send_item(CMD_WRITE, 8'(x), 8'(z), h, W_W'($urandom), W_W'($urandom));
		cell_written[x * GRID_SIZE + z] = 1'b1;
	endtask

	task automatic fill_if_blank(input int x, input int z);
		if (!cell_written[x * GRID_SIZE + z])
			write_height(x, z, rand_height());
	endtask

	task automatic sample_at(input logic signed [W_W-1:0] wx, input logic signed [W_W-1:0] wz);
		int cx;
		int cz;
		cx = world_cell(wx);
		cz = world_cell(wz);
		// write any untouched neighbour first
		fill_if_blank(cx, cz);
		fill_if_blank(cx, clamp_cell(cz + 1));
		fill_if_blank(clamp_cell(cx + 1), cz);
		fill_if_blank(clamp_cell(cx + 1), clamp_cell(cz + 1));
		send_item(CMD_SAMPLE, 8'($urandom), 8'($urandom), H_W'($urandom), wx, wz);
		last_x = cx;
		last_z = cz;
	endtask

	initial begin
		int level;
		int len;
		int r;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				res_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 45) begin
					level = 1;
					len   = $urandom_range(1, 40);
				end else if (r < 88) begin
					level = 0;
					len   = $urandom_range(1, 3);
				end else if (r < 97) begin
					level = 0;
					len   = $urandom_range(4, 12);
				end else begin
					level = 0;
					len   = $urandom_range(20, 60);
				end
				res_ch.ready <= 1'(level);
				repeat (len) @(posedge clk);
			end
		end
	end

	initial begin
		int r;
		int x;
		int z;
		int u;
		bit hold_done;
		hold_done = 1'b0;
		arst_n              <= 1'b0;
		cmd_ch.valid        <= 1'b0;
		cmd_ch.command      <= CMD_WRITE;
		cmd_ch.grid_x       <= '0;
		cmd_ch.grid_z       <= '0;
		cmd_ch.height_value <= '0;
		cmd_ch.world_x      <= '0;
		cmd_ch.world_z      <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// near corner: exact tap, half cell, saturated from far outside
		write_height(0, 0, 16'sh7fff);
		write_height(0, 1, 16'sh8000);
		write_height(1, 0, 16'sh8000);
		write_height(1, 1, 16'sh7fff);
		sample_at(W_W'(-WORLD_LIMIT), W_W'(-WORLD_LIMIT));
		sample_at(W_W'(-WORLD_LIMIT + CELL_SPAN / 2), W_W'(-WORLD_LIMIT + CELL_SPAN / 2));
		sample_at(17'sh10000, 17'sh10000);

		// far corner: the +200.0 edge clamps to the last row and column
		write_height(GRID_SIZE - 2, GRID_SIZE - 2, 16'sh8000);
		write_height(GRID_SIZE - 2, GRID_SIZE - 1, 16'sh7fff);
		write_height(GRID_SIZE - 1, GRID_SIZE - 2, 16'sh7fff);
		write_height(GRID_SIZE - 1, GRID_SIZE - 1, 16'sh8000);
		sample_at(W_W'(WORLD_LIMIT), W_W'(WORLD_LIMIT));
		sample_at(17'sh0ffff, 17'sh0ffff);
		sample_at(W_W'(WORLD_LIMIT - 1), W_W'(WORLD_LIMIT - 1));

		// rounding ties, positive then negative after an overwrite
		write_height(100, 100, 16'sd1);
		write_height(100, 101, 16'sd0);
		write_height(101, 100, 16'sd1);
		write_height(101, 101, 16'sd0);
		sample_at(W_W'(100 * CELL_SPAN - WORLD_LIMIT),
			W_W'(100 * CELL_SPAN + CELL_SPAN / 2 - WORLD_LIMIT));
		write_height(100, 100, -16'sd1);
		write_height(101, 100, -16'sd1);
		sample_at(W_W'(100 * CELL_SPAN - WORLD_LIMIT),
			W_W'(100 * CELL_SPAN + CELL_SPAN / 2 - WORLD_LIMIT));

		while (items_sent < ITEMS) begin
			r = $urandom_range(0, 99);
			if (!hold_done && items_sent >= ITEMS / 2) begin
				// hold the result side off while samples keep coming
				hold_done    = 1'b1;
				hold_request = 1'b1;
				burst_left   = 24;
				repeat (16) sample_at(world_in_cell(last_x), world_in_cell(last_z));
			end else if (r < 12) begin
				write_height($urandom_range(0, GRID_SIZE - 1), $urandom_range(0, GRID_SIZE - 1),
					rand_height());
			end else if (r < 22) begin
				x = clamp_cell(last_x + $urandom_range(0, 1));
				z = clamp_cell(last_z + $urandom_range(0, 1));
				write_height(x, z, rand_height());
			end else if (r < 60) begin
				x = clamp_cell(last_x + $urandom_range(0, 2) - 1);
				z = clamp_cell(last_z + $urandom_range(0, 2) - 1);
				sample_at(world_in_cell(x), world_in_cell(z));
			end else if (r < 88) begin
				u = $urandom_range(0, U_MAX);
				x = $urandom_range(0, U_MAX);
				sample_at(W_W'(u - WORLD_LIMIT), W_W'(x - WORLD_LIMIT));
			end else if (r < 96) begin
				sample_at(W_W'($urandom), W_W'($urandom));
			end else begin
				if ($urandom_range(0, 1))
					sample_at(rim_world(), rim_world());
				else
					sample_at(rim_world(), world_in_cell($urandom_range(0, GRID_SIZE - 1)));
			end
		end
		cmd_ch.valid <= 1'b0;
		@(posedge clk);

		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("Sent %0d commands: %0d height writes and %0d samples across the whole map.",
			items_sent, writes_sent, samples_sent);
		$display("Compared %0d sampled heights, %0d failures.", compared, failures);
		if (failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
